// ----- hw/rtl/tlc_pkg.sv -----
// Shared types, constants and a helper function for the triangle local coordinates pipeline.
`timescale 1ns / 1ps

package tlc_pkg;

    // Half and full turn in Q10.22 degrees.
    localparam logic signed [36:0] HALF_TURN = 37'sd754974720;
    localparam logic signed [36:0] FULL_TURN = 37'sd1509949440;

    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;

    localparam int EPS_W = 16;

    // Unwrapped longitudes can drift several turns away from the raw range.
    typedef logic signed [35:0] lon_t;

    // Wrap front end: coordinates carried through the three wrap stages.
    typedef struct packed {
        logic signed [31:0] plon;
        logic signed [31:0] plat;
        logic signed [31:0] lat1;
        logic signed [31:0] lat2;
        logic signed [31:0] lat3;
        lon_t               lon1;
        lon_t               lon2;
        lon_t               lon3;
    } front_t;

    // Edge and point differences.
    typedef struct packed {
        logic signed [31:0] ctx;
        logic signed [31:0] cty;
        logic signed [32:0] cpx;
        logic signed [32:0] cpy;
        logic signed [31:0] dx;
        logic signed [32:0] dy;
    } diff_t;

    // Six partial products of the determinant and the numerators.
    typedef struct packed {
        logic signed [64:0] pa;
        logic signed [64:0] pb;
        logic signed [64:0] pc;
        logic signed [64:0] pd;
        logic signed [64:0] pe;
        logic signed [64:0] pf;
    } prod_t;

    // Determinant and numerators, exact in Q.44.
    typedef struct packed {
        logic signed [65:0] det;
        logic signed [65:0] numx;
        logic signed [65:0] numy;
    } sum_t;

    // Divider lane state: a shared divisor and, per lane, a remainder and a dividend/quotient shift word.
    typedef struct packed {
        logic [64:0] d;
        logic [64:0] rx;
        logic [31:0] qx;
        logic [64:0] ry;
        logic [31:0] qy;
        logic        negx;
        logic        negy;
        logic        ovfx;
        logic        ovfy;
        logic        degen;
    } div_t;

    // Bring v into [c - 180, c + 180) by whole turns.
    function automatic lon_t wrap_near(input lon_t v, input lon_t c);
        logic signed [36:0] t;
        t = 37'(v) - 37'(c) + HALF_TURN + 37'sd6 * FULL_TURN;
        if (t >= 37'sd8 * FULL_TURN) t = t - 37'sd8 * FULL_TURN;
        if (t >= 37'sd4 * FULL_TURN) t = t - 37'sd4 * FULL_TURN;
        if (t >= 37'sd2 * FULL_TURN) t = t - 37'sd2 * FULL_TURN;
        if (t >= FULL_TURN) t = t - FULL_TURN;
        return lon_t'(37'(c) - HALF_TURN + t);
    endfunction

endpackage

// ----- hw/rtl/triangle_local_coordinates.sv -----
// Top level of the triangle local coordinates pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | point, vertex1..3 lon/lat (Q10.22)
//  out     | output    | out_valid/out_stall| coord_x, coord_y (Q8.24), degenerate, saturated
//  cfg     | input     | cfg_write_en       | cfg_write_data = degenerate_epsilon
//
// One beat enters per cycle when not stalled and passes three longitude wrap stages,
// a difference stage, product, sum and setup stages, 32 divider stages of one quotient
// bit each, and the output register. Reset clears all valid bits and sets epsilon to 1.
// While a result waits under out_stall the whole pipeline holds and in_stall is high.
`timescale 1ns / 1ps

module triangle_local_coordinates (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [tlc_pkg::EPS_W-1:0]   cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          point_lon,
    input  logic signed [31:0]          point_lat,
    input  logic signed [31:0]          vertex1_lon,
    input  logic signed [31:0]          vertex1_lat,
    input  logic signed [31:0]          vertex2_lon,
    input  logic signed [31:0]          vertex2_lat,
    input  logic signed [31:0]          vertex3_lon,
    input  logic signed [31:0]          vertex3_lat,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          coord_x,
    output logic signed [31:0]          coord_y,
    output logic                        degenerate,
    output logic                        saturated
);
    import tlc_pkg::*;

    logic             adv;
    logic [EPS_W-1:0] eps_reg;
    logic             front_valid, mult_valid, div_valid;
    diff_t            front_data;
    div_t             mult_data, div_data;
    logic             out_valid_reg;
    logic [31:0]      x_reg, y_reg, x_next, y_next;
    logic             degen_reg, sat_reg, sat_next;

    // The pipeline advances unless a result is held under stall.
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Degenerate threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_W'(1);
        else if (cfg_write_en)
            eps_reg <= cfg_write_data;
    end

    tlc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_beat     (in_valid),
        .point_lon   (point_lon),
        .point_lat   (point_lat),
        .vertex1_lon (vertex1_lon),
        .vertex1_lat (vertex1_lat),
        .vertex2_lon (vertex2_lon),
        .vertex2_lat (vertex2_lat),
        .vertex3_lon (vertex3_lon),
        .vertex3_lat (vertex3_lat),
        .out_valid   (front_valid),
        .out_data    (front_data)
    );

    tlc_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .epsilon   (eps_reg),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (mult_valid),
        .out_data  (mult_data)
    );

    tlc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mult_valid),
        .in_data   (mult_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // Sign, saturation and degenerate forcing.
    always_comb
    begin
        logic satx, saty;
        satx = div_data.ovfx ||
               (div_data.negx ? (div_data.qx > COORD_MIN) : div_data.qx[31]);
        saty = div_data.ovfy ||
               (div_data.negy ? (div_data.qy > COORD_MIN) : div_data.qy[31]);
        if (div_data.degen)
        begin
            x_next   = '0;
            y_next   = '0;
            sat_next = 1'b0;
        end
        else
        begin
            x_next   = satx ? (div_data.negx ? COORD_MIN : COORD_MAX)
                            : (div_data.negx ? -div_data.qx : div_data.qx);
            y_next   = saty ? (div_data.negy ? COORD_MIN : COORD_MAX)
                            : (div_data.negy ? -div_data.qy : div_data.qy);
            sat_next = satx || saty;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            degen_reg <= div_data.degen;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coord_x    = x_reg;
    assign coord_y    = y_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

    // A degenerate result is all zero and never flagged as clipped.
    a_degen : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !saturated && coord_x == 0 && coord_y == 0)
        else $error("degenerate result not cleared");
    // A clipped result carries a limit value in at least one coordinate.
    a_sat : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (coord_x == COORD_MAX || coord_x == COORD_MIN ||
             coord_y == COORD_MAX || coord_y == COORD_MIN))
        else $error("saturated flag without limit value");
    // Input is held back only while a result waits.
    a_stall : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

// ----- hw/rtl/tlc_front.sv -----
// Longitude unwrapping stages and difference stage.
`timescale 1ns / 1ps

module tlc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_beat,
    input  logic signed [31:0]  point_lon,
    input  logic signed [31:0]  point_lat,
    input  logic signed [31:0]  vertex1_lon,
    input  logic signed [31:0]  vertex1_lat,
    input  logic signed [31:0]  vertex2_lon,
    input  logic signed [31:0]  vertex2_lat,
    input  logic signed [31:0]  vertex3_lon,
    input  logic signed [31:0]  vertex3_lat,
    output logic                out_valid,
    output tlc_pkg::diff_t      out_data
);
    import tlc_pkg::*;

    logic   [3:0] valid_reg;
    front_t       s1_reg, s2_reg, s3_reg;
    front_t       s1_next, s2_next, s3_next;
    diff_t        s4_reg, s4_next;

    // Stage 1 unwraps vertex 1 around the point.
    always_comb
    begin
        s1_next.plon = point_lon;
        s1_next.plat = point_lat;
        s1_next.lat1 = vertex1_lat;
        s1_next.lat2 = vertex2_lat;
        s1_next.lat3 = vertex3_lat;
        s1_next.lon1 = wrap_near(lon_t'(vertex1_lon), lon_t'(point_lon));
        s1_next.lon2 = lon_t'(vertex2_lon);
        s1_next.lon3 = lon_t'(vertex3_lon);
    end

    // Stage 2 unwraps vertex 2 around vertex 1.
    always_comb
    begin
        s2_next = s1_reg;
        s2_next.lon2 = wrap_near(s1_reg.lon2, s1_reg.lon1);
    end

    // Stage 3 unwraps vertex 3 around vertex 2.
    always_comb
    begin
        s3_next = s2_reg;
        s3_next.lon3 = wrap_near(s2_reg.lon3, s2_reg.lon2);
    end

    // Stage 4 forms the edge and point differences.
    always_comb
    begin
        lon_t d21, d31, dp1;
        d21 = s3_reg.lon2 - s3_reg.lon1;
        d31 = s3_reg.lon3 - s3_reg.lon1;
        dp1 = lon_t'(s3_reg.plon) - s3_reg.lon1;
        s4_next.ctx = d21[31:0];
        s4_next.cty = d31[31:0];
        s4_next.dx  = dp1[31:0];
        s4_next.cpx = 33'(s3_reg.lat2) - 33'(s3_reg.lat1);
        s4_next.cpy = 33'(s3_reg.lat3) - 33'(s3_reg.lat1);
        s4_next.dy  = 33'(s3_reg.plat) - 33'(s3_reg.lat1);
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[2:0], in_beat};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = s4_reg;

endmodule

// ----- hw/rtl/tlc_mult.sv -----
// Product, sum and divider setup stages.
`timescale 1ns / 1ps

module tlc_mult (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [tlc_pkg::EPS_W-1:0]   epsilon,
    input  logic                        in_valid,
    input  tlc_pkg::diff_t              in_data,
    output logic                        out_valid,
    output tlc_pkg::div_t               out_data
);
    import tlc_pkg::*;

    logic  [2:0] valid_reg;
    prod_t       p_reg, p_next;
    sum_t        s_reg, s_next;
    div_t        d_reg, d_next;

    // Stage 5: six independent products.
    always_comb
    begin
        p_next.pa = 65'(in_data.ctx) * 65'(in_data.cpy);
        p_next.pb = 65'(in_data.cty) * 65'(in_data.cpx);
        p_next.pc = 65'(in_data.cpy) * 65'(in_data.dx);
        p_next.pd = 65'(in_data.cty) * 65'(in_data.dy);
        p_next.pe = 65'(in_data.ctx) * 65'(in_data.dy);
        p_next.pf = 65'(in_data.cpx) * 65'(in_data.dx);
    end

    // Stage 6: determinant and numerators.
    always_comb
    begin
        s_next.det  = 66'(p_reg.pa) - 66'(p_reg.pb);
        s_next.numx = 66'(p_reg.pc) - 66'(p_reg.pd);
        s_next.numy = 66'(p_reg.pe) - 66'(p_reg.pf);
    end

    // Stage 7: magnitudes, signs, degenerate test, overflow test, divider seed.
    always_comb
    begin
        logic        det_neg;
        logic [65:0] dneg, xneg, yneg;
        logic [64:0] dmag, xmag, ymag;
        det_neg = s_reg.det[65];
        dneg = -s_reg.det;
        xneg = -s_reg.numx;
        yneg = -s_reg.numy;
        dmag = det_neg ? dneg[64:0] : s_reg.det[64:0];
        xmag = s_reg.numx[65] ? xneg[64:0] : s_reg.numx[64:0];
        ymag = s_reg.numy[65] ? yneg[64:0] : s_reg.numy[64:0];
        d_next.d     = dmag;
        d_next.degen = dmag <= 65'(epsilon);
        d_next.negx  = s_reg.numx[65] ^ det_neg;
        d_next.negy  = s_reg.numy[65] ^ det_neg;
        // The quotient cannot fit 32 bits when the shifted numerator reaches d * 2^32.
        d_next.ovfx  = {8'd0, xmag, 24'd0} >= {dmag, 32'd0};
        d_next.ovfy  = {8'd0, ymag, 24'd0} >= {dmag, 32'd0};
        d_next.rx    = 65'(xmag[64:8]);
        d_next.qx    = {xmag[7:0], 24'd0};
        d_next.ry    = 65'(ymag[64:8]);
        d_next.qy    = {ymag[7:0], 24'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
            s_reg <= s_next;
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = d_reg;

endmodule

// ----- hw/rtl/tlc_div.sv -----
// Two-lane restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module tlc_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  tlc_pkg::div_t   in_data,
    output logic            out_valid,
    output tlc_pkg::div_t   out_data
);
    import tlc_pkg::*;

    localparam int STEPS = 32;

    logic [STEPS-1:0] valid_reg;
    div_t             stage_reg  [STEPS];
    div_t             stage_next [STEPS];

    // One restoring step: shift in a dividend bit, subtract when it fits.
    function automatic logic [96:0] div_step(input logic [64:0] r, input logic [31:0] q,
                                              input logic [64:0] d);
        logic [65:0] rs;
        logic        ge;
        logic [65:0] diff;
        rs   = {r, q[31]};
        ge   = rs >= {1'b0, d};
        diff = rs - {1'b0, d};
        return {(ge ? diff[64:0] : rs[64:0]), q[30:0], ge};
    endfunction

    // Each stage takes one step on both lanes.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        div_t src;
        if (k == 0)
        begin : g_first
            assign src = in_data;
        end
        else
        begin : g_rest
            assign src = stage_reg[k-1];
        end

        always_comb
        begin
            stage_next[k] = src;
            {stage_next[k].rx, stage_next[k].qx} = div_step(src.rx, src.qx, src.d);
            {stage_next[k].ry, stage_next[k].qy} = div_step(src.ry, src.qy, src.d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < STEPS; k++)
                stage_reg[k] <= stage_next[k];
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_data  = stage_reg[STEPS-1];

    // Without overflow the final remainder stays below the divisor.
    a_rem_x : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ovfx && !out_data.degen |-> out_data.rx < out_data.d)
        else $error("x remainder not below divisor");
    a_rem_y : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ovfy && !out_data.degen |-> out_data.ry < out_data.d)
        else $error("y remainder not below divisor");
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("divider valid bits moved while held");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the triangle local coordinates pipeline.
`timescale 1ns / 1ps

module tb_top;

    localparam int PIPE_LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic signed [63:0] HALF_Q22 = 64'sd754974720;
    localparam logic signed [63:0] FULL_Q22 = 64'sd1509949440;

    typedef struct packed {
        logic signed [31:0] plon;
        logic signed [31:0] plat;
        logic signed [31:0] v1lon;
        logic signed [31:0] v1lat;
        logic signed [31:0] v2lon;
        logic signed [31:0] v2lat;
        logic signed [31:0] v3lon;
        logic signed [31:0] v3lat;
    } query_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               degen;
        logic               sat;
    } local_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    query_t in_beat = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic degenerate;
    logic saturated;

    query_t pending_queries[$];
    local_t expected_coords[$];
    logic [15:0] model_epsilon = 16'd1;
    int error_count = 0;
    int checked_count = 0;
    int degen_count = 0;
    int sat_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int stall_gap = 0;
    bit timed_out = 1'b0;

    triangle_local_coordinates i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_lon(in_beat.plon), .point_lat(in_beat.plat),
        .vertex1_lon(in_beat.v1lon), .vertex1_lat(in_beat.v1lat),
        .vertex2_lon(in_beat.v2lon), .vertex2_lat(in_beat.v2lat),
        .vertex3_lon(in_beat.v3lon), .vertex3_lat(in_beat.v3lat),
        .out_valid(out_valid), .out_stall(out_stall),
        .coord_x(coord_x), .coord_y(coord_y),
        .degenerate(degenerate), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Bring v into [c - 180, c + 180) by whole turns.
    function automatic logic signed [63:0] unwrap_lon(logic signed [63:0] v,
                                                      logic signed [63:0] c);
        logic signed [63:0] base;
        logic signed [63:0] m;
        base = c - HALF_Q22;
        m = (v - base) % FULL_Q22;
        if (m < 0) m = m + FULL_Q22;
        return base + m;
    endfunction

    // Signed numerator * 2^24 / |det|, truncated, with saturation.
    function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
                                                    logic [127:0] det_mag,
                                                    logic det_neg, ref logic sat);
        logic neg;
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] lim;
        neg = num[127] ^ det_neg;
        mag = num[127] ? -num : num;
        q = (mag << 24) / det_mag;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
        begin
            sat = 1'b1;
            q = lim;
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    // Compute the expected local coordinates of one query.
    function automatic local_t predict_coords(query_t q, logic [15:0] eps);
        logic signed [63:0] lon1, lon2, lon3, ctx, cty, cpx, cpy, dx, dy;
        logic signed [127:0] det, numx, numy;
        logic [127:0] det_mag;
        logic sat;
        local_t r;
        lon1 = unwrap_lon(64'(q.v1lon), 64'(q.plon));
        lon2 = unwrap_lon(64'(q.v2lon), lon1);
        lon3 = unwrap_lon(64'(q.v3lon), lon2);
        ctx = lon2 - lon1;
        cty = lon3 - lon1;
        cpx = 64'(q.v2lat) - 64'(q.v1lat);
        cpy = 64'(q.v3lat) - 64'(q.v1lat);
        dx = 64'(q.plon) - lon1;
        dy = 64'(q.plat) - 64'(q.v1lat);
        det = 128'(ctx) * 128'(cpy) - 128'(cty) * 128'(cpx);
        det_mag = det[127] ? -det : det;
        r = '0;
        if (det_mag <= 128'(eps))
        begin
            r.degen = 1'b1;
            return r;
        end
        numx = 128'(cpy) * 128'(dx) - 128'(cty) * 128'(dy);
        numy = 128'(ctx) * 128'(dy) - 128'(cpx) * 128'(dx);
        sat = 1'b0;
        r.x = scaled_quotient(numx, det_mag, det[127], sat);
        r.y = scaled_quotient(numy, det_mag, det[127], sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s at beat %0d: got %h, expected %h", what, checked_count,
                 got, want);
        error_count++;
    endtask

    // Driver: present queued queries with random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_coords.push_back(predict_coords(in_beat, model_epsilon));
                send_gap = pick_gap();
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap == 0 && pending_queries.size() > 0)
                begin
                    in_beat <= pending_queries.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // Monitor: check accepted results and drive random stalls.
    always @(posedge clk)
    begin
        local_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_coords.size() == 0)
                begin
                    report_mismatch("unexpected result beat", coord_x, 32'd0);
                end
                else
                begin
                    want = expected_coords.pop_front();
                    if (coord_x !== want.x) report_mismatch("coord_x", coord_x, want.x);
                    if (coord_y !== want.y) report_mismatch("coord_y", coord_y, want.y);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", 32'(degenerate), 32'(want.degen));
                    if (saturated !== want.sat)
                        report_mismatch("saturated", 32'(saturated), 32'(want.sat));
                    degen_count += int'(want.degen);
                    sat_count += int'(want.sat);
                end
                checked_count++;
            end
            if (stall_gap > 0)
            begin
                stall_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 9) < 3) stall_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic query_t random_query(int shape);
        query_t q;
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom};
        if (shape < 6)
        begin
            // Well-formed triangle near the point, scaled to a random size.
            int sh;
            sh = $urandom_range(4, 29);
            q.v1lon = q.plon + ($signed($urandom) >>> sh);
            q.v1lat = q.plat + ($signed($urandom) >>> sh);
            q.v2lon = q.v1lon + ($signed($urandom) >>> sh);
            q.v2lat = q.v1lat + ($signed($urandom) >>> sh);
            q.v3lon = q.v1lon + ($signed($urandom) >>> sh);
            q.v3lat = q.v1lat + ($signed($urandom) >>> sh);
        end
        else if (shape < 7)
        begin
            // Collinear vertices.
            q.v2lon = q.v1lon + 32'sd1000;
            q.v2lat = q.v1lat + 32'sd1000;
            q.v3lon = q.v1lon + 32'sd3000;
            q.v3lat = q.v1lat + 32'sd3000;
        end
        else if (shape < 8)
        begin
            // Tiny determinant close to epsilon.
            q.v2lon = q.v1lon + 32'($urandom_range(0, 300));
            q.v2lat = q.v1lat;
            q.v3lon = q.v1lon;
            q.v3lat = q.v1lat + 32'($urandom_range(0, 300));
        end
        return q;
    endfunction

    task automatic push_query(logic signed [31:0] a, b, c, d, e, f, g, h);
        query_t q;
        q = {a, b, c, d, e, f, g, h};
        pending_queries.push_back(q);
    endtask

    // Sampled at the falling edge so the driver's updates have settled.
    task automatic wait_drained();
        while (pending_queries.size() > 0 || in_valid || expected_coords.size() > 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_epsilon(logic [15:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        model_epsilon = value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sd4194304;

    initial
    begin
        logic [15:0] eps_set[4];
        eps_set = '{16'd0, 16'd65535, 16'd1, 16'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unit triangle, wraps, degenerate, saturation, extremes.
        push_query(ONE / 4, ONE / 4, 0, 0, ONE, 0, 0, ONE);
        push_query(0, 0, 0, 0, 0, 0, 0, 0);
        push_query(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        push_query(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        push_query(MAXV, 0, MINV, 0, MAXV, ONE, MINV, MAXV);
        push_query(MINV, MAXV, MAXV, MINV, MINV, 0, MAXV, MINV);
        push_query(ONE * 179, 0, -ONE * 179, 0, -ONE * 178, 0, -ONE * 179, ONE);
        push_query(-ONE * 179, 0, ONE * 179, 0, ONE * 178, 0, ONE * 179, ONE);
        push_query(ONE * 180, 0, 0, 0, ONE, 0, 0, ONE);
        push_query(0, 0, ONE * 180, 0, ONE * 181, 0, ONE * 180, ONE);
        push_query(MAXV, MAXV, 0, 0, 1, 0, 0, 1);
        push_query(MINV, MAXV, 0, 0, 1, 0, 0, 1);
        push_query(0, 0, 0, 0, 1, 0, 0, 1);
        push_query(0, 0, 0, 0, 2, 0, 0, 1);
        push_query(5, 7, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
        push_query(ONE, ONE, 0, 0, 0, ONE, ONE, 0);
        push_query(-1, -1, 0, 0, MAXV, 0, 0, MINV);
        wait_drained();

        // Random phases, each under a different epsilon.
        for (int phase = 0; phase < 4; phase++)
        begin
            set_epsilon(phase == 3 ? 16'($urandom) : eps_set[phase]);
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                pending_queries.push_back(random_query($urandom_range(0, 9)));
            wait_drained();
        end

        $display("Checked %0d result beats over 5 epsilon settings: %0d degenerate, %0d saturated.",
                 checked_count, degen_count, sat_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
